/* hdl/smdr_pkg.sv */
package smdr_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned WordW  = 32;
  localparam int unsigned ProdW  = ValueW + WordW;
  localparam int unsigned InW    = ValueW + 2 * WordW;
  localparam int unsigned UserW  = 2;
  localparam int unsigned DivSteps = ProdW;
  localparam int unsigned CntW   = $clog2(DivSteps);

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic mul_acc;
    logic div_step;
    logic res_ld;
  } smdr_cmd_t;

  typedef struct packed {
    logic div_zero;
  } smdr_sts_t;

endpackage

/* hdl/smdr_dp.sv */
module smdr_dp
  import smdr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smdr_cmd_t         cmd_i,
  output smdr_sts_t         sts_o,
  input  logic [InW-1:0]    in_data_i,
  output logic [ValueW-1:0] scaled_o,
  output logic              div_zero_o,
  output logic              overflow_o
);

  logic [ValueW-1:0]   value_q;
  logic [WordW-1:0]    mult_q;
  logic [WordW-1:0]    div_q;
  logic [2*WordW-1:0]  mprod_q;
  logic [ProdW-1:0]    prod_q;
  logic [WordW-1:0]    rem_q;
  logic [ValueW-1:0]   scaled_q;
  logic                dbz_q;
  logic                ovf_q;

  logic [WordW-1:0]    mul_a;
  logic [2*WordW-1:0]  mul_p;
  logic [WordW:0]      trial;
  logic [WordW-1:0]    diff;
  logic                q_bit;
  logic                round_up;
  logic [ValueW-1:0]   low_inc;
  logic                carry;

  assign mul_a = cmd_i.mul_hi ? value_q[ValueW-1:WordW] : value_q[WordW-1:0];
  assign mul_p = mul_a * mult_q;

  // restoring step: shift one product bit into the remainder
  assign trial = {rem_q, prod_q[ProdW-1]};
  assign diff  = trial[WordW-1:0] - div_q;
  assign q_bit = (trial >= {1'b0, div_q});

  assign round_up = ({rem_q, 1'b0} > {1'b0, div_q});
  assign low_inc  = prod_q[ValueW-1:0] + {{(ValueW-1){1'b0}}, round_up};
  assign carry    = round_up && (&prod_q[ValueW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_data_i[ValueW-1:0];
      mult_q  <= in_data_i[ValueW+WordW-1:ValueW];
      div_q   <= in_data_i[InW-1:ValueW+WordW];
    end
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      mprod_q <= mul_p;
    end
    if (cmd_i.mul_hi) begin
      prod_q <= {{(ProdW-2*WordW){1'b0}}, mprod_q};
    end else if (cmd_i.mul_acc) begin
      prod_q <= prod_q + {mprod_q, {WordW{1'b0}}};
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      prod_q <= {prod_q[ProdW-2:0], q_bit};
      rem_q  <= q_bit ? diff : trial[WordW-1:0];
    end
    if (cmd_i.res_ld) begin
      if (div_q == '0) begin
        scaled_q <= '0;
        dbz_q    <= 1'b1;
        ovf_q    <= 1'b0;
      end else begin
        scaled_q <= low_inc;
        dbz_q    <= 1'b0;
        ovf_q    <= (|prod_q[ProdW-1:ValueW]) || carry;
      end
    end
  end

  assign sts_o.div_zero = (div_q == '0);
  assign scaled_o   = scaled_q;
  assign div_zero_o = dbz_q;
  assign overflow_o = ovf_q;

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_ld && div_q == '0) |=> (dbz_q && scaled_q == '0 && !ovf_q))
    else $error("zero divisor result wrong");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_step) |-> (rem_q < div_q))
    else $error("remainder not below divisor");

endmodule

/* hdl/smdr_ctrl.sv */
module smdr_ctrl
  import smdr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output smdr_cmd_t cmd_o,
  input  smdr_sts_t sts_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMul0  = 3'd1;
  localparam logic [2:0] StMul1  = 3'd2;
  localparam logic [2:0] StMul2  = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StRound = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovalid_q, ovalid_d;
  logic            out_free;

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StMul0;
        end
      end
      StMul0: begin
        if (sts_i.div_zero) begin
          state_d = StRound;
        end else begin
          cmd_o.mul_lo = 1'b1;
          state_d      = StMul1;
        end
      end
      StMul1: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = StMul2;
      end
      StMul2: begin
        cmd_o.mul_acc = 1'b1;
        cnt_d         = '0;
        state_d       = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = StRound;
        end
      end
      StRound: begin
        if (out_free) begin
          cmd_o.res_ld = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;

  a_res_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_ld |-> out_free)
    else $error("result loaded over a pending transfer");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (cnt_q < CntW'(DivSteps)))
    else $error("divide step count overrun");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StMul0))
    else $error("accepted item did not start");

endmodule

/* hdl/scaled_mul_div_round_unit.sv */
// Computes round(value * multiplier / divisor) over the full 96-bit product, rounding up
// only when twice the remainder exceeds the divisor (ties round down). scaled carries the
// low 64 bits; overflow flags a rounded quotient of 2^64 or more; a zero divisor returns
// scaled = 0 with divide_by_zero set. One item is processed at a time: with a nonzero
// divisor the low and high multiplies on the shared 32x32 multiplier, an accumulate step,
// the one-bit-per-cycle restoring divider and a rounding step follow an input transfer
// before the idle state takes the next; a zero divisor skips the multiplies and divider.
// The result sits in an output register, so the next input transfer may occur while it
// waits to be taken; the following result then waits in the rounding state until it is.
module scaled_mul_div_round_unit
  import smdr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [InW-1:0]    s_axis_tdata_i,   // value[63:0], multiplier[95:64], divisor[127:96]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [ValueW-1:0] m_axis_tdata_o,   // scaled[63:0]
  output logic [UserW-1:0]  m_axis_tuser_o    // divide_by_zero[0], overflow[1]
);

  smdr_cmd_t cmd;
  smdr_sts_t sts;
  logic      dbz;
  logic      ovf;

  smdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  smdr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata_i),
    .scaled_o   (m_axis_tdata_o),
    .div_zero_o (dbz),
    .overflow_o (ovf)
  );

  assign m_axis_tuser_o = {ovf, dbz};

endmodule
